### sv/vfs_pkg.sv
package vfs_pkg;

    localparam int MACHINE_COUNT = 4;
    localparam int FIELD_W       = 4;
    localparam int WIDTH_W       = 3;
    localparam int MU_W          = 3;
    localparam int IDX_W         = FIELD_W * MACHINE_COUNT;
    localparam int OFF_W         = $clog2(FIELD_W * MACHINE_COUNT);
    localparam int SETTLE_W      = $clog2(MACHINE_COUNT + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MACHINES_USED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES_0      = 3'd1;

    localparam logic [MU_W-1:0]    RESET_MACHINES_USED = 3'd4;
    localparam logic [FIELD_W-1:0] RESET_STATES        = 4'd8;

    localparam int DEF_STATE_BITS    = 12;
    localparam int DEF_VISITED_DEPTH = 4096;
    localparam int DEF_STACK_DEPTH   = 1024;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam int ERR_W = 2;
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd3;

    // Bits needed for a field holding count states (a zero count acts as one).
    function automatic logic [WIDTH_W-1:0] field_bits(input logic [FIELD_W-1:0] count);
        logic [WIDTH_W-1:0] b;
        if (count <= 4'd1)
            b = 3'd0;
        else if (count <= 4'd2)
            b = 3'd1;
        else if (count <= 4'd4)
            b = 3'd2;
        else if (count <= 4'd8)
            b = 3'd3;
        else
            b = 3'd4;
        return b;
    endfunction

    function automatic logic [FIELD_W-1:0] field_mask(input logic [WIDTH_W-1:0] bits);
        logic [FIELD_W:0] m;
        m = ((FIELD_W + 1)'(1) << bits) - (FIELD_W + 1)'(1);
        return m[FIELD_W-1:0];
    endfunction

endpackage

### sv/vfs_ram.sv
module vfs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/vfs_fifo.sv
module vfs_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

### sv/vfs_front.sv
module vfs_front import vfs_pkg::*; #(
    parameter int STATE_BITS    = DEF_STATE_BITS,
    parameter int VISITED_DEPTH = DEF_VISITED_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          kind,
    input  logic [STATE_BITS-1:0]         packed_state,
    input  logic                          clear_busy,
    input  logic                          q_full,
    output logic                          q_wr,
    output logic                          q_kind,
    output logic [STATE_BITS-1:0]         q_state,
    output logic                          q_oob,
    output logic [$clog2(VISITED_DEPTH)-1:0] q_idx
);

    localparam int VADDR_W = $clog2(VISITED_DEPTH);

    logic [MU_W-1:0]     mu_reg;
    logic [FIELD_W-1:0]  cnt_reg [MACHINE_COUNT];
    logic [SETTLE_W-1:0] settle_reg, settle_next;

    logic [MU_W-1:0]     m_eff;
    logic [FIELD_W-1:0]  cnt_eff [MACHINE_COUNT];
    logic [WIDTH_W-1:0]  fw      [MACHINE_COUNT];

    logic [IDX_W-1:0]    weight_reg  [MACHINE_COUNT];
    logic [IDX_W-1:0]    weight_next [MACHINE_COUNT];
    logic [OFF_W-1:0]    off_reg     [MACHINE_COUNT];
    logic [OFF_W-1:0]    off_next    [MACHINE_COUNT];

    logic [IDX_W-1:0]    ext;
    logic [IDX_W-1:0]    shifted [MACHINE_COUNT];
    logic [FIELD_W-1:0]  fld     [MACHINE_COUNT];
    logic [IDX_W-1:0]    idx_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg <= RESET_MACHINES_USED;
            for (int i = 0; i < MACHINE_COUNT; i++)
            begin
                cnt_reg[i] <= RESET_STATES;
            end
            settle_reg <= SETTLE_W'(MACHINE_COUNT);
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MACHINES_USED)
                begin
                    mu_reg <= cfg_data[MU_W-1:0];
                end
                for (int i = 0; i < MACHINE_COUNT; i++)
                begin
                    if (cfg_index == CFG_STATES_0 + CFG_IDX_W'(i))
                    begin
                        cnt_reg[i] <= cfg_data[FIELD_W-1:0];
                    end
                end
            end
            settle_reg <= settle_next;
        end
    end

    // Re-derive offsets and weights after every write; hold items until settled.
    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_we)
        begin
            settle_next = SETTLE_W'(MACHINE_COUNT);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
    end

    always_comb
    begin
        m_eff = mu_reg;
        if (mu_reg == '0)
        begin
            m_eff = MU_W'(1);
        end
        else if (mu_reg > MU_W'(MACHINE_COUNT))
        begin
            m_eff = MU_W'(MACHINE_COUNT);
        end
        for (int i = 0; i < MACHINE_COUNT; i++)
        begin
            cnt_eff[i] = (cnt_reg[i] == '0) ? FIELD_W'(1) : cnt_reg[i];
            fw[i]      = field_bits(cnt_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MACHINE_COUNT - 1; i++)
        begin
            if (i + 1 >= int'(m_eff))
            begin
                weight_next[i] = IDX_W'(1);
                off_next[i]    = '0;
            end
            else
            begin
                weight_next[i] = IDX_W'(weight_reg[i + 1] * IDX_W'(cnt_eff[i + 1]));
                off_next[i]    = off_reg[i + 1] + OFF_W'(fw[i + 1]);
            end
        end
        weight_next[MACHINE_COUNT - 1] = IDX_W'(1);
        off_next[MACHINE_COUNT - 1]    = '0;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MACHINE_COUNT; i++)
        begin
            weight_reg[i] <= weight_next[i];
            off_reg[i]    <= off_next[i];
        end
    end

    assign ext = IDX_W'(packed_state);

    always_comb
    begin
        idx_sum = '0;
        for (int i = 0; i < MACHINE_COUNT; i++)
        begin
            shifted[i] = ext >> off_reg[i];
            fld[i]     = shifted[i][FIELD_W-1:0] & field_mask(fw[i]);
            if (i < int'(m_eff))
            begin
                idx_sum = idx_sum + IDX_W'(IDX_W'(fld[i]) * weight_reg[i]);
            end
        end
    end

    assign item_stall = clear_busy || (settle_reg != '0) || q_full;
    assign q_wr       = item_valid && !item_stall;
    assign q_kind     = kind;
    assign q_state    = packed_state;
    assign q_oob      = (32'(idx_sum) >= 32'(VISITED_DEPTH));
    assign q_idx      = VADDR_W'(idx_sum);

endmodule

### sv/vfs_back.sv
module vfs_back import vfs_pkg::*; #(
    parameter int STATE_BITS    = DEF_STATE_BITS,
    parameter int VISITED_DEPTH = DEF_VISITED_DEPTH,
    parameter int STACK_DEPTH   = DEF_STACK_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    output logic                              q_rd,
    input  logic                              q_kind,
    input  logic [STATE_BITS-1:0]             q_state,
    input  logic                              q_oob,
    input  logic [$clog2(VISITED_DEPTH)-1:0]  q_idx,
    output logic                              clear_busy,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [STATE_BITS-1:0]             popped_state,
    output logic                              was_pushed,
    output logic [$clog2(STACK_DEPTH+1)-1:0]  stack_count,
    output logic                              stack_empty,
    output logic [ERR_W-1:0]                  error_code
);

    localparam int VADDR_W  = $clog2(VISITED_DEPTH);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [VADDR_W-1:0]    clr_reg, clr_next;
    logic [SP_W-1:0]       sp_reg, sp_next, sp_m1;

    logic                  w_kind_reg;
    logic [STATE_BITS-1:0] w_state_reg;
    logic                  w_oob_reg;
    logic [VADDR_W-1:0]    w_idx_reg;

    logic                  valid_reg, valid_next;
    logic [STATE_BITS-1:0] popped_reg, popped_next;
    logic                  pushed_reg, pushed_next;
    logic [SP_W-1:0]       count_reg, count_next;
    logic                  empty_reg, empty_next;
    logic [ERR_W-1:0]      err_reg, err_next;

    logic                  vis_we, vis_re;
    logic [VADDR_W-1:0]    vis_waddr;
    logic [0:0]            vis_wdata, vis_rdata;
    logic                  stk_we, stk_re;
    logic [STATE_BITS-1:0] stk_rdata;

    assign sp_m1 = sp_reg - SP_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        sp_next     = sp_reg;
        q_rd        = 1'b0;
        vis_re      = 1'b0;
        stk_re      = 1'b0;
        vis_we      = 1'b0;
        vis_waddr   = w_idx_reg;
        vis_wdata   = 1'b1;
        stk_we      = 1'b0;
        valid_next  = (valid_reg && !result_stall) ? 1'b0 : valid_reg;
        popped_next = popped_reg;
        pushed_next = pushed_reg;
        count_next  = count_reg;
        empty_next  = empty_reg;
        err_next    = err_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = 1'b0;
                if (clr_reg == VADDR_W'(VISITED_DEPTH - 1))
                begin
                    state_next = ST_ISSUE;
                end
                else
                begin
                    clr_next = clr_reg + VADDR_W'(1);
                end
            end
            ST_ISSUE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    vis_re     = 1'b1;
                    stk_re     = (sp_reg != '0);
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!valid_reg || !result_stall)
                begin
                    state_next  = ST_ISSUE;
                    valid_next  = 1'b1;
                    popped_next = '0;
                    pushed_next = 1'b0;
                    err_next    = ERR_OK;
                    if (w_kind_reg == KIND_PUSH)
                    begin
                        if (w_oob_reg)
                        begin
                            err_next = ERR_RANGE;
                        end
                        else if (!vis_rdata[0])
                        begin
                            if (sp_reg >= SP_W'(STACK_DEPTH))
                            begin
                                err_next = ERR_FULL;
                            end
                            else
                            begin
                                stk_we      = 1'b1;
                                vis_we      = 1'b1;
                                sp_next     = sp_reg + SP_W'(1);
                                pushed_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (sp_reg == '0)
                        begin
                            err_next = ERR_EMPTY;
                        end
                        else
                        begin
                            sp_next     = sp_m1;
                            popped_next = stk_rdata;
                        end
                    end
                    count_next = sp_next;
                    empty_next = (sp_next == '0);
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            w_kind_reg  <= q_kind;
            w_state_reg <= q_state;
            w_oob_reg   <= q_oob;
            w_idx_reg   <= q_idx;
        end
        popped_reg <= popped_next;
        pushed_reg <= pushed_next;
        count_reg  <= count_next;
        empty_reg  <= empty_next;
        err_reg    <= err_next;
    end

    vfs_ram #(
        .WIDTH (1),
        .DEPTH (VISITED_DEPTH)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (q_idx),
        .rdata (vis_rdata)
    );

    vfs_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (sp_reg[STACK_AW-1:0]),
        .wdata (w_state_reg),
        .re    (stk_re),
        .raddr (sp_m1[STACK_AW-1:0]),
        .rdata (stk_rdata)
    );

    assign clear_busy   = (state_reg == ST_CLEAR);
    assign result_valid = valid_reg;
    assign popped_state = popped_reg;
    assign was_pushed   = pushed_reg;
    assign stack_count  = count_reg;
    assign stack_empty  = empty_reg;
    assign error_code   = err_reg;

endmodule

### sv/visited_filter_search_stack_top.sv
// Depth-first search frontier with a visited bitmap. A push (kind 0) turns
// packed_state into a mixed-radix index from the per-machine state counts and,
// when the index is in range, the bitmap entry is clear and the stack is not
// full, stacks the state and marks it; a pop (kind 1) returns the top of the
// stack. Each item gives one result with the stack depth, an empty flag and an
// error code. After reset the block sweeps the bitmap clear, one entry a cycle,
// and holds item_stall high meanwhile. A configuration write holds item_stall
// high while field offsets and weights are re-derived. Items enter a short
// queue at up to one a cycle while item_stall is low; the execution side reads
// the bitmap and stack memories in its issue state and updates them in its
// execute state, and takes no new item until it is through with the last one.
module visited_filter_search_stack_top import vfs_pkg::*; #(
    parameter int STATE_BITS    = DEF_STATE_BITS,
    parameter int VISITED_DEPTH = DEF_VISITED_DEPTH,
    parameter int STACK_DEPTH   = DEF_STACK_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic                             kind,
    input  logic [STATE_BITS-1:0]            packed_state,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [STATE_BITS-1:0]            popped_state,
    output logic                             was_pushed,
    output logic [$clog2(STACK_DEPTH+1)-1:0] stack_count,
    output logic                             stack_empty,
    output logic [ERR_W-1:0]                 error_code
);

    localparam int VADDR_W = $clog2(VISITED_DEPTH);
    localparam int Q_W     = 1 + STATE_BITS + 1 + VADDR_W;

    logic                  clear_busy;
    logic                  q_wr, q_rd, q_full, q_empty;
    logic                  wr_kind, wr_oob;
    logic [STATE_BITS-1:0] wr_state;
    logic [VADDR_W-1:0]    wr_idx;
    logic [Q_W-1:0]        q_wdata, q_rdata;
    logic                  rd_kind, rd_oob;
    logic [STATE_BITS-1:0] rd_state;
    logic [VADDR_W-1:0]    rd_idx;

    assign cfg_ready = 1'b1;

    vfs_front #(
        .STATE_BITS    (STATE_BITS),
        .VISITED_DEPTH (VISITED_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .packed_state (packed_state),
        .clear_busy   (clear_busy),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_kind       (wr_kind),
        .q_state      (wr_state),
        .q_oob        (wr_oob),
        .q_idx        (wr_idx)
    );

    assign q_wdata = {wr_kind, wr_state, wr_oob, wr_idx};

    vfs_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {rd_kind, rd_state, rd_oob, rd_idx} = q_rdata;

    vfs_back #(
        .STATE_BITS    (STATE_BITS),
        .VISITED_DEPTH (VISITED_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rd         (q_rd),
        .q_kind       (rd_kind),
        .q_state      (rd_state),
        .q_oob        (rd_oob),
        .q_idx        (rd_idx),
        .clear_busy   (clear_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .popped_state (popped_state),
        .was_pushed   (was_pushed),
        .stack_count  (stack_count),
        .stack_empty  (stack_empty),
        .error_code   (error_code)
    );

endmodule
